/* rtl/tss_pkg.sv */
package tss_pkg;

   localparam int DATA_W        = 32;
   localparam int CMD_W         = 3;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 5;
   localparam int DEPTH_DEFAULT = 16;

   localparam logic [CMD_W-1:0] CMD_PUSH_A = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP_A  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH_B = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_B  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LIST_A = 3'd4;
   localparam logic [CMD_W-1:0] CMD_LIST_B = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

/* rtl/tss_seq.sv */
module tss_seq #(
   parameter int DEPTH = tss_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tss_pkg::CMD_W-1:0]       req_cmd,
   input  logic [tss_pkg::DATA_W-1:0]      req_value,
   output tss_pkg::mem_ctl_type            mem_ctl,
   output logic [$clog2(DEPTH)-1:0]        mem_addr,
   output logic [tss_pkg::DATA_W-1:0]      mem_wr_data,
   input  logic [tss_pkg::DATA_W-1:0]      mem_rd_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tss_pkg::STATUS_W-1:0]    rsp_status,
   output logic [tss_pkg::DATA_W-1:0]      rsp_data,
   output logic [tss_pkg::COUNT_W-1:0]     rsp_count_a,
   output logic [tss_pkg::COUNT_W-1:0]     rsp_count_b,
   output logic                            rsp_last
);
   import tss_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP  = 2'd1;
   localparam logic [1:0] S_LIST = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       size_a_ff, size_a_in;
   logic [CW-1:0]       size_b_ff, size_b_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                list_b_ff, list_b_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]  rsp_count_a_ff, rsp_count_a_in;
   logic [COUNT_W-1:0]  rsp_count_b_ff, rsp_count_b_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                accept;
   logic                load;
   logic                full;
   logic [CW-1:0]       pop_a_addr;
   logic [CW-1:0]       pop_b_addr;
   logic [CW-1:0]       idx_next;
   logic [CW-1:0]       list_size;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign accept     = req_valid && !req_stall;
   assign full       = ((CW+1)'(size_a_ff) + (CW+1)'(size_b_ff)) >= (CW+1)'(DEPTH);
   assign pop_a_addr = size_a_ff - CW'(1);
   assign pop_b_addr = CW'(DEPTH) - size_b_ff;
   assign idx_next   = idx_ff + CW'(1);
   assign list_size  = list_b_ff ? size_b_ff : size_a_ff;

   always_comb begin
      state_in      = state_ff;
      size_a_in     = size_a_ff;
      size_b_in     = size_b_ff;
      idx_in        = idx_ff;
      list_b_in     = list_b_ff;
      load          = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;
      mem_ctl       = '0;
      mem_addr      = '0;
      mem_wr_data   = req_value;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_PUSH_A: begin
                     load = 1'b1;
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        mem_addr      = size_a_ff[AW-1:0];
                        size_a_in     = size_a_ff + CW'(1);
                        rsp_data_in   = req_value;
                     end
                  end
                  CMD_PUSH_B: begin
                     load = 1'b1;
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        mem_addr      = AW'(DEPTH - 1) - size_b_ff[AW-1:0];
                        size_b_in     = size_b_ff + CW'(1);
                        rsp_data_in   = req_value;
                     end
                  end
                  CMD_POP_A: begin
                     if (size_a_ff == '0) begin
                        load          = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = pop_a_addr[AW-1:0];
                        size_a_in     = pop_a_addr;
                        state_in      = S_POP;
                     end
                  end
                  CMD_POP_B: begin
                     if (size_b_ff == '0) begin
                        load          = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = pop_b_addr[AW-1:0];
                        size_b_in     = size_b_ff - CW'(1);
                        state_in      = S_POP;
                     end
                  end
                  CMD_LIST_A: begin
                     if (size_a_ff == '0) begin
                        load          = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = '0;
                        idx_in        = '0;
                        list_b_in     = 1'b0;
                        state_in      = S_LIST;
                     end
                  end
                  CMD_LIST_B: begin
                     if (size_b_ff == '0) begin
                        load          = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = AW'(DEPTH - 1);
                        idx_in        = '0;
                        list_b_in     = 1'b1;
                        state_in      = S_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            load        = 1'b1;
            rsp_data_in = mem_rd_data;
            state_in    = S_IDLE;
         end
         S_LIST: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_data_in = mem_rd_data;
               rsp_last_in = (idx_next == list_size);
               if (idx_next == list_size) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in        = idx_next;
                  mem_ctl.rd_en = 1'b1;
                  mem_addr      = list_b_ff ? AW'(DEPTH - 1) - idx_next[AW-1:0]
                                            : idx_next[AW-1:0];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_count_a_in = COUNT_W'(size_a_in);
      rsp_count_b_in = COUNT_W'(size_b_in);
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_a_ff    <= '0;
         size_b_ff    <= '0;
         idx_ff       <= '0;
         list_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_a_ff    <= size_a_in;
         size_b_ff    <= size_b_in;
         idx_ff       <= idx_in;
         list_b_ff    <= list_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_data_ff    <= rsp_data_in;
         rsp_count_a_ff <= rsp_count_a_in;
         rsp_count_b_ff <= rsp_count_b_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_data    = rsp_data_ff;
   assign rsp_count_a = rsp_count_a_ff;
   assign rsp_count_b = rsp_count_b_ff;
   assign rsp_last    = rsp_last_ff;

   a_sizes_fit: assert property (@(posedge clock) disable iff (reset)
      ((CW+1)'(size_a_ff) + (CW+1)'(size_b_ff)) <= (CW+1)'(DEPTH))
      else $error("stack sizes exceed memory depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result loaded over a pending transfer");

   a_single_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.rd_en && mem_ctl.wr_en))
      else $error("memory read and write in the same cycle");

   a_pop_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> $past(mem_ctl.rd_en))
      else $error("pop result without a memory read");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("input open while a command is in progress");

endmodule

/* rtl/two_stacks_shared_array.sv */
// Two LIFO stacks in one DEPTH-word memory: stack A fills from entry 0 upward,
// stack B from entry DEPTH-1 downward, and a push is refused with a full status
// once they meet. A push or a full or empty answer loads the result directly;
// a pop loads the word from its registered memory read. A list reads its first
// word, then streams one word per cycle while the result side keeps taking
// them, holding the input stalled until the word marked last has been handed
// over. The memory needs no clearing after reset.
module two_stacks_shared_array #(
   parameter int DEPTH = tss_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tss_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [tss_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tss_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [tss_pkg::DATA_W-1:0]  rsp_data,
   output logic [tss_pkg::COUNT_W-1:0]        rsp_count_a,
   output logic [tss_pkg::COUNT_W-1:0]        rsp_count_b,
   output logic                               rsp_last
);
   import tss_pkg::*;

   localparam int AW = $clog2(DEPTH);

   mem_ctl_type       mem_ctl;
   logic [AW-1:0]     mem_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic [DATA_W-1:0] mem_rd_data_ff;
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rsp_data_raw;

   tss_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_value   (req_value),
      .mem_ctl     (mem_ctl),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_data    (rsp_data_raw),
      .rsp_count_a (rsp_count_a),
      .rsp_count_b (rsp_count_b),
      .rsp_last    (rsp_last)
   );

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[mem_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         mem_rd_data_ff <= mem[mem_addr];
      end
   end

   assign rsp_data = rsp_data_raw;

endmodule

/* bench/two_stacks_shared_array_test.sv */
`timescale 1ns / 100ps

module two_stacks_shared_array_test;
   import tss_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int REQUEST_GOAL = 195;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] data;
      logic [COUNT_W-1:0]       count_a;
      logic [COUNT_W-1:0]       count_b;
      logic                     last;
   } stack_result_type;

   class stack_pair_model_type;
      logic [DATA_W-1:0] words [DEPTH];
      int unsigned fill_a = 0;
      int unsigned fill_b = 0;
      stack_result_type due_results [$];
      int errors = 0;
      int commands = 0;
      int results = 0;
      int full_refusals = 0;
      int empty_answers = 0;
      int listings = 0;
      int longest_listing = 0;

      function int pending();
         return due_results.size();
      endfunction

      function void add_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] data,
                               logic last);
         stack_result_type r;
         r.status  = status;
         r.data    = data;
         r.count_a = fill_a[COUNT_W-1:0];
         r.count_b = fill_b[COUNT_W-1:0];
         r.last    = last;
         due_results.push_back(r);
         if (status == STAT_FULL) full_refusals++;
         if (status == STAT_EMPTY) empty_answers++;
      endfunction

      function void apply_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
         int unsigned k;
         if (cmd <= CMD_LIST_B) commands++;
         case (cmd)
            CMD_PUSH_A: begin
               if (fill_a + fill_b >= DEPTH) begin
                  add_result(STAT_FULL, '0, 1'b1);
               end else begin
                  words[fill_a] = value;
                  fill_a++;
                  add_result(STAT_OK, value, 1'b1);
               end
            end
            CMD_PUSH_B: begin
               if (fill_a + fill_b >= DEPTH) begin
                  add_result(STAT_FULL, '0, 1'b1);
               end else begin
                  words[DEPTH - 1 - fill_b] = value;
                  fill_b++;
                  add_result(STAT_OK, value, 1'b1);
               end
            end
            CMD_POP_A: begin
               if (fill_a == 0) begin
                  add_result(STAT_EMPTY, '0, 1'b1);
               end else begin
                  fill_a--;
                  add_result(STAT_OK, words[fill_a], 1'b1);
               end
            end
            CMD_POP_B: begin
               if (fill_b == 0) begin
                  add_result(STAT_EMPTY, '0, 1'b1);
               end else begin
                  k = DEPTH - fill_b;
                  fill_b--;
                  add_result(STAT_OK, words[k], 1'b1);
               end
            end
            CMD_LIST_A: begin
               listings++;
               if (fill_a == 0) begin
                  add_result(STAT_EMPTY, '0, 1'b1);
               end else begin
                  for (k = 0; k < fill_a; k++) add_result(STAT_OK, words[k], k + 1 == fill_a);
                  if (fill_a > longest_listing) longest_listing = fill_a;
               end
            end
            CMD_LIST_B: begin
               listings++;
               if (fill_b == 0) begin
                  add_result(STAT_EMPTY, '0, 1'b1);
               end else begin
                  for (k = 0; k < fill_b; k++) begin
                     add_result(STAT_OK, words[DEPTH - 1 - k], k + 1 == fill_b);
                  end
                  if (fill_b > longest_listing) longest_listing = fill_b;
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void check_field(string field, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void compare_result(stack_result_type got);
         stack_result_type want;
         results++;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer, expected none, actual status %0h data %0h",
                     $time, got.status, got.data);
         end else begin
            want = due_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("data", want.data, got.data);
            check_field("count_a", want.count_a, got.count_a);
            check_field("count_b", want.count_b, got.count_b);
            check_field("last", want.last, got.last);
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_cmd;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_data;
   logic [COUNT_W-1:0]       rsp_count_a;
   logic [COUNT_W-1:0]       rsp_count_b;
   logic                     rsp_last;

   stack_pair_model_type model = new();
   bit quiet = 1'b0;
   int hold_cycles = 0;

   two_stacks_shared_array #(.DEPTH(DEPTH)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_data    (rsp_data),
      .rsp_count_a (rsp_count_a),
      .rsp_count_b (rsp_count_b),
      .rsp_last    (rsp_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) model.apply_command(req_cmd, req_value);
         if (rsp_valid && !rsp_stall) begin
            model.compare_result({rsp_status, rsp_data, rsp_count_a, rsp_count_b, rsp_last});
         end
      end
   end

   initial begin
      int wait_n;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            wait_n = hold_cycles;
            hold_cycles = 0;
         end else begin
            wait_n = quiet ? 0 : $urandom_range(0, 19);
         end
         if (wait_n > 0) begin
            rsp_stall = 1'b1;
            repeat (wait_n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   function automatic logic signed [DATA_W-1:0] random_word();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return -1;
         3: return 0;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd   = cmd;
      req_value = value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid = 1'b0;
      while (model.pending() != 0) @(negedge clock);
   endtask

   task automatic fill_episode();
      int bias;
      case ($urandom_range(0, 3))
         0: bias = 0;
         1: bias = 100;
         default: bias = $urandom_range(0, 100);
      endcase
      while (model.fill_a + model.fill_b < DEPTH) begin
         send_command(($urandom_range(0, 99) < bias) ? CMD_PUSH_A : CMD_PUSH_B, random_word());
      end
      repeat ($urandom_range(1, 2)) begin
         send_command($urandom_range(0, 1) ? CMD_PUSH_A : CMD_PUSH_B, random_word());
      end
      send_command(CMD_LIST_A, random_word());
      send_command(CMD_LIST_B, random_word());
   endtask

   task automatic drain_episode();
      while (model.fill_a > 0 || model.fill_b > 0) begin
         if (model.fill_b == 0 || (model.fill_a > 0 && $urandom_range(0, 1)))
            send_command(CMD_POP_A, random_word());
         else
            send_command(CMD_POP_B, random_word());
      end
      send_command(CMD_POP_A, random_word());
      send_command(CMD_POP_B, random_word());
      send_command($urandom_range(0, 1) ? CMD_LIST_A : CMD_LIST_B, random_word());
   endtask

   task automatic mixed_episode();
      int pick;
      repeat ($urandom_range(6, 14)) begin
         pick = $urandom_range(0, 99);
         if (pick < 38)
            send_command($urandom_range(0, 1) ? CMD_PUSH_A : CMD_PUSH_B, random_word());
         else if (pick < 72)
            send_command($urandom_range(0, 1) ? CMD_POP_A : CMD_POP_B, random_word());
         else if (pick < 90)
            send_command($urandom_range(0, 1) ? CMD_LIST_A : CMD_LIST_B, random_word());
         else
            send_command(CMD_W'($urandom_range(CMD_LIST_B + 1, 7)), random_word());
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_cmd   = CMD_PUSH_A;
      req_value = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      send_command(CMD_LIST_A, 0);
      send_command(CMD_LIST_B, -1);
      send_command(CMD_POP_A, 32'sh7FFF_FFFF);
      send_command(CMD_POP_B, 32'sh8000_0000);
      send_command(CMD_PUSH_A, 32'sh7FFF_FFFF);
      send_command(CMD_PUSH_A, 32'sh8000_0000);
      send_command(CMD_PUSH_B, 0);
      send_command(CMD_PUSH_B, -1);
      send_command(CMD_W'(6), 32'sh5555_5555);
      send_command(CMD_LIST_A, 0);
      send_command(CMD_LIST_B, 0);
      send_command(CMD_W'(7), 32'shAAAA_AAAA);
      send_command(CMD_POP_A, 0);
      send_command(CMD_POP_B, 0);
      send_command(CMD_LIST_A, 0);
      send_command(CMD_LIST_B, 0);

      wait_drain();
      hold_cycles = 150;
      fill_episode();
      wait_drain();
      drain_episode();

      while (model.commands < REQUEST_GOAL) begin
         quiet = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 3))
            0: fill_episode();
            1: drain_episode();
            default: mixed_episode();
         endcase
      end
      quiet = 1'b0;

      wait_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d commands and %0d result transfers: %0d full refusals,",
               model.commands, model.results, model.full_refusals);
      $display("%0d empty answers, %0d listings up to %0d words long.",
               model.empty_answers, model.listings, model.longest_listing);
      if (model.errors == 0 && model.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results never arrived", model.errors, model.pending());
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout at %0t with %0d results outstanding", $time, model.pending());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
